FILE: hdl/kalman_tilt_angle_filter_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef KALMAN_TILT_ANGLE_FILTER_MACROS_SVH
`define KALMAN_TILT_ANGLE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/kta_pkg.sv
`timescale 1ns / 1ps
package kta_pkg;

    localparam int AXES_DEF = 2;

    // Register reset values, Q4.28
    localparam logic [30:0] ANGLE_NOISE_RST   = 31'd268435;
    localparam logic [30:0] BIAS_NOISE_RST    = 31'd805306;
    localparam logic [30:0] MEASURE_NOISE_RST = 31'd134217728;
    localparam logic [28:0] SAMPLE_PERIOD_RST = 29'd2684355;

    localparam logic signed [31:0] COV_ONE = 32'sd268435456;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REG_ANGLE_NOISE   = 2'd0,
        REG_BIAS_NOISE    = 2'd1,
        REG_MEASURE_NOISE = 2'd2,
        REG_SAMPLE_PERIOD = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV0,
        ST_DIV1,
        ST_DONE
    } t_state;

    // Multiply-accumulate steps, in issue order
    typedef enum logic [3:0] {
        OP_ANG_PRED  = 4'd0,
        OP_PAA       = 4'd1,
        OP_PAB       = 4'd2,
        OP_PBA       = 4'd3,
        OP_PBB       = 4'd4,
        OP_AA_CORR   = 4'd5,
        OP_AB_CORR   = 4'd6,
        OP_BA_CORR   = 4'd7,
        OP_BB_CORR   = 4'd8,
        OP_ANG_CORR  = 4'd9,
        OP_BIAS_CORR = 4'd10
    } t_op;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = S32_MAX;
        end else if (v < -42'sd2147483648) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/kta_if.sv
`timescale 1ns / 1ps
interface kta_in_if;
    logic               valid;
    logic               ready;
    logic               axis_sel;
    logic signed [24:0] measured_angle;
    logic signed [27:0] rate;

    modport source (output valid, axis_sel, measured_angle, rate, input ready);
    modport sink   (input valid, axis_sel, measured_angle, rate, output ready);
endinterface

interface kta_out_if;
    logic               valid;
    logic               ready;
    logic               axis_out;
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;

    modport source (output valid, axis_out, angle_estimate, bias_estimate, input ready);
    modport sink   (input valid, axis_out, angle_estimate, bias_estimate, output ready);
endinterface

FILE: hdl/kta_div.sv
`timescale 1ns / 1ps
module kta_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kta_pkg::t_div_req i_req,
    output kta_pkg::t_div_rsp o_rsp
);
    import kta_pkg::*;

    logic [31:0] num_mag;
    logic [32:0] den_mag;
    logic        ovf;
    logic [33:0] t1, t2;
    logic        ge1, ge2;
    logic [32:0] rem1, rem2;

    logic        r_busy, r_done;
    logic [3:0]  r_cnt;
    logic [32:0] r_rem, r_dm;
    logic [31:0] r_sh, r_qm;
    logic        r_neg, r_sat, r_zero;

    // Operand magnitudes and overflow check: quotient would reach 2^32
    assign num_mag = i_req.num[31] ? 32'(-i_req.num) : 32'(i_req.num);
    assign den_mag = i_req.den[32] ? 33'(-i_req.den) : 33'(i_req.den);
    assign ovf     = {5'd0, num_mag} >= {den_mag, 4'd0};

    // Two restoring steps per cycle
    always_comb begin
        t1   = {r_rem, r_sh[31]};
        ge1  = t1 >= {1'b0, r_dm};
        rem1 = ge1 ? 33'(t1 - {1'b0, r_dm}) : t1[32:0];
        t2   = {rem1, r_sh[30]};
        ge2  = t2 >= {1'b0, r_dm};
        rem2 = ge2 ? 33'(t2 - {1'b0, r_dm}) : t2[32:0];
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_neg  <= i_req.num[31] ^ i_req.den[32];
            r_zero <= (i_req.den == '0);
            r_sat  <= ovf;
            r_dm   <= den_mag;
            r_rem  <= {5'd0, num_mag[31:4]};
            r_sh   <= {num_mag[3:0], 28'd0};
            r_qm   <= '0;
            r_cnt  <= '0;
            if (i_req.den == '0 || ovf) begin
                r_done <= 1'b1;
            end else begin
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_rem <= rem2;
            r_sh  <= {r_sh[29:0], 2'b00};
            r_qm  <= {r_qm[29:0], ge1, ge2};
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Apply sign and saturate the quotient; a zero denominator gives zero
    always_comb begin
        o_rsp.done = r_done;
        if (r_zero) begin
            o_rsp.quot = '0;
        end else if (r_sat) begin
            o_rsp.quot = r_neg ? S32_MIN : S32_MAX;
        end else if (r_neg) begin
            o_rsp.quot = (r_qm > 32'h8000_0000) ? S32_MIN : 32'(-r_qm);
        end else begin
            o_rsp.quot = r_qm[31] ? S32_MAX : r_qm;
        end
    end
endmodule

FILE: hdl/kalman_tilt_angle_filter.sv
`timescale 1ns / 1ps
// Two-state tilt filter (angle and gyro bias), one filter per axis.
// Input channel i_item carries axis_sel, measured_angle and rate (Q16.16).
// Output channel o_result returns axis_out, angle_estimate and
// bias_estimate (Q16.16, saturated), one result per input transfer.
// Registers are written over the APB port at byte address 4*index:
// angle_noise, bias_noise, measure_noise, sample_period (Q4.28).
// One item runs on a single shared 34x33 multiplier with a rounding
// accumulator: eleven multiply-accumulate steps, each a multiply state then
// an accumulate state, plus two gain divisions on a radix-4 divider that
// each hold the sequencer until the divider is done (early for a zero
// denominator or an overflowing quotient). A new item is taken only when
// idle, so the block does not accept an item before the last result is
// loaded into the output register.
// The result sits in an output register: a stalled receiver holds it while
// the next item is computed; the block waits before publishing a second one.
// Synchronous reset restores register defaults, zero angle and bias, and
// unit covariance diagonals for every axis.
module kalman_tilt_angle_filter #(
    parameter int AXES = kta_pkg::AXES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kta_in_if.sink      i_item,
    kta_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kta_pkg::*;
    `include "kalman_tilt_angle_filter_macros.svh"

    localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic signed [66:0] HALF_LSB = 67'sd134217728;

    // Configuration registers
    logic [30:0] r_angle_noise, r_bias_noise, r_measure_noise;
    logic [28:0] r_sample_period;
    t_reg_idx    reg_sel;
    logic        cfg_wr;

    // Per-axis state
    logic signed [31:0] r_ang_st [AXES];
    logic signed [31:0] r_bias_st[AXES];
    logic signed [31:0] r_aa_st  [AXES];
    logic signed [31:0] r_ab_st  [AXES];
    logic signed [31:0] r_ba_st  [AXES];
    logic signed [31:0] r_bb_st  [AXES];

    // Sequencer and working registers
    t_state             r_state, n_state;
    t_op                r_op;
    logic [IW-1:0]      r_idx;
    logic               r_sel;
    logic signed [24:0] r_meas;
    logic signed [27:0] r_rate;
    logic signed [31:0] r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic signed [31:0] r_k0, r_k1, r_err;
    logic signed [66:0] r_prod;
    logic signed [31:0] r_base;
    logic               r_neg;

    // Output register
    logic               r_out_valid;
    logic               r_out_axis;
    logic signed [31:0] r_out_ang, r_out_bias;

    logic               accept, load_out;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] base;
    logic               neg;
    logic signed [66:0] rnd;
    logic signed [41:0] scaled, acc_sum;
    logic signed [31:0] acc_res;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // APB register access
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_sel)
            REG_ANGLE_NOISE:   prdata = {1'b0, r_angle_noise};
            REG_BIAS_NOISE:    prdata = {1'b0, r_bias_noise};
            REG_MEASURE_NOISE: prdata = {1'b0, r_measure_noise};
            REG_SAMPLE_PERIOD: prdata = {3'd0, r_sample_period};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise   <= ANGLE_NOISE_RST;
            r_bias_noise    <= BIAS_NOISE_RST;
            r_measure_noise <= MEASURE_NOISE_RST;
            r_sample_period <= SAMPLE_PERIOD_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ANGLE_NOISE:   r_angle_noise   <= pwdata[30:0];
                REG_BIAS_NOISE:    r_bias_noise    <= pwdata[30:0];
                REG_MEASURE_NOISE: r_measure_noise <= pwdata[30:0];
                REG_SAMPLE_PERIOD: r_sample_period <= pwdata[28:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_item.valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                if (r_op == OP_PBB) begin
                    n_state = ST_DIV0;
                end else if (r_op == OP_BIAS_CORR) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIV0: if (div_rsp.done) n_state = ST_DIV1;
            ST_DIV1: if (div_rsp.done) n_state = ST_MUL;
            ST_DONE: if (!r_out_valid || o_result.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_item.ready  = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = r_paa;
        div_req.den   = 33'(signed'({2'b00, r_measure_noise})) + 33'(r_paa);
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: i_item.ready = 1'b1;
            ST_ACC:  div_req.start = (r_op == OP_PBB);
            ST_DIV0: begin
                div_req.start = div_rsp.done;
                div_req.num   = r_pba;
            end
            ST_DONE: load_out = !r_out_valid || o_result.ready;
            default: ;
        endcase
    end

    assign accept = i_item.valid && i_item.ready;

    // Multiplier operand and accumulator base selection
    always_comb begin
        mul_a = 34'(r_k0);
        mul_b = 33'(signed'({4'd0, r_sample_period}));
        base  = r_ang;
        neg   = 1'b0;
        case (r_op)
            OP_ANG_PRED: mul_a = 34'(r_rate) - 34'(r_bias);
            OP_PAA: begin
                mul_a = 34'(signed'({3'd0, r_angle_noise})) - 34'(r_pab) - 34'(r_pba);
                base  = r_paa;
            end
            OP_PAB: begin
                mul_a = 34'(r_pbb);
                base  = r_pab;
                neg   = 1'b1;
            end
            OP_PBA: begin
                mul_a = 34'(r_pbb);
                base  = r_pba;
                neg   = 1'b1;
            end
            OP_PBB: begin
                mul_a = 34'(signed'({3'd0, r_bias_noise}));
                base  = r_pbb;
            end
            OP_AA_CORR: begin
                mul_b = 33'(r_paa);
                base  = r_paa;
                neg   = 1'b1;
            end
            OP_AB_CORR: begin
                mul_b = 33'(r_pab);
                base  = r_pab;
                neg   = 1'b1;
            end
            OP_BA_CORR: begin
                mul_a = 34'(r_k1);
                mul_b = 33'(r_paa);
                base  = r_pba;
                neg   = 1'b1;
            end
            OP_BB_CORR: begin
                mul_a = 34'(r_k1);
                mul_b = 33'(r_pab);
                base  = r_pbb;
                neg   = 1'b1;
            end
            OP_ANG_CORR: mul_b = 33'(r_err);
            OP_BIAS_CORR: begin
                mul_a = 34'(r_k1);
                mul_b = 33'(r_err);
                base  = r_bias;
            end
            default: ;
        endcase
    end

    // Round half up, scale back by 2^28, accumulate and saturate
    always_comb begin
        rnd     = r_prod + HALF_LSB;
        scaled  = 42'(rnd >>> 28);
        acc_sum = r_neg ? 42'(r_base) - scaled : 42'(r_base) + scaled;
        acc_res = sat32(acc_sum);
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_ANG_PRED;
            for (int i = 0; i < AXES; i++) begin
                r_ang_st[i]  <= '0;
                r_bias_st[i] <= '0;
                r_aa_st[i]   <= COV_ONE;
                r_ab_st[i]   <= '0;
                r_ba_st[i]   <= '0;
                r_bb_st[i]   <= COV_ONE;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_op <= OP_ANG_PRED;
            end else if (r_state == ST_ACC && r_op != OP_BIAS_CORR) begin
                r_op <= t_op'(4'(r_op) + 4'd1);
            end
            if (r_state == ST_ACC) begin
                case (r_op)
                    OP_AA_CORR:   r_aa_st[r_idx]   <= acc_res;
                    OP_AB_CORR:   r_ab_st[r_idx]   <= acc_res;
                    OP_BA_CORR:   r_ba_st[r_idx]   <= acc_res;
                    OP_BB_CORR:   r_bb_st[r_idx]   <= acc_res;
                    OP_ANG_CORR:  r_ang_st[r_idx]  <= acc_res;
                    OP_BIAS_CORR: r_bias_st[r_idx] <= acc_res;
                    default: ;
                endcase
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= (AXES > 1) ? IW'(i_item.axis_sel) : '0;
            r_sel  <= i_item.axis_sel;
            r_meas <= i_item.measured_angle;
            r_rate <= i_item.rate;
            r_ang  <= r_ang_st[(AXES > 1) ? IW'(i_item.axis_sel) : '0];
            r_bias <= r_bias_st[(AXES > 1) ? IW'(i_item.axis_sel) : '0];
            r_paa  <= r_aa_st[(AXES > 1) ? IW'(i_item.axis_sel) : '0];
            r_pab  <= r_ab_st[(AXES > 1) ? IW'(i_item.axis_sel) : '0];
            r_pba  <= r_ba_st[(AXES > 1) ? IW'(i_item.axis_sel) : '0];
            r_pbb  <= r_bb_st[(AXES > 1) ? IW'(i_item.axis_sel) : '0];
        end
        if (r_state == ST_MUL) begin
            r_prod <= mul_a * mul_b;
            r_base <= base;
            r_neg  <= neg;
        end
        if (r_state == ST_ACC) begin
            case (r_op)
                OP_ANG_PRED, OP_ANG_CORR: r_ang  <= acc_res;
                OP_PAA:                   r_paa  <= acc_res;
                OP_PAB:                   r_pab  <= acc_res;
                OP_PBA:                   r_pba  <= acc_res;
                OP_PBB:                   r_pbb  <= acc_res;
                OP_BIAS_CORR:             r_bias <= acc_res;
                default: ;
            endcase
        end
        // Innovation, taken once the predicted angle is final
        if (r_state == ST_DIV0) begin
            r_err <= sat32(42'(r_meas) - 42'(r_ang));
        end
        if (r_state == ST_DIV0 && div_rsp.done) r_k0 <= div_rsp.quot;
        if (r_state == ST_DIV1 && div_rsp.done) r_k1 <= div_rsp.quot;
    end

    // Gain divider
    kta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Result register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_axis <= r_sel;
            r_out_ang  <= r_ang;
            r_out_bias <= r_bias;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.axis_out       = r_out_axis;
    assign o_result.angle_estimate = r_out_ang;
    assign o_result.bias_estimate  = r_out_bias;

    `KTA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept,
        r_state == ST_MUL && r_op == OP_ANG_PRED, "accepted item did not start at first step")
    `KTA_ASSERT_NOW(a_div_done_in_wait, i_clk, i_rst_n, div_rsp.done,
        r_state == ST_DIV0 || r_state == ST_DIV1, "divider finished outside a gain wait")
    `KTA_ASSERT_NEXT(a_acc_follow, i_clk, i_rst_n, r_state == ST_ACC,
        r_state == ST_MUL || r_state == ST_DIV0 || r_state == ST_DONE,
        "bad successor of accumulate")
    `KTA_ASSERT_NEXT(a_done_publishes, i_clk, i_rst_n, r_state == ST_DONE && !r_out_valid,
        r_out_valid && r_state == ST_IDLE, "finished result was not published")
endmodule
